### sv/urde_pkg.sv
// Shared types, codes and the CRC8 byte update for the UART register datagram engine.
// No dependencies; imported by every module of the block.
package urde_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RX    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SYNC   = 3'd1,
    ST_MASTER = 3'd2,
    ST_REG    = 3'd3,
    ST_CRC    = 3'd4
  } status_e;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [7:0] SYNC_BYTE   = 8'h05;
  localparam logic [7:0] MASTER_BYTE = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  // echo lengths in bytes and index of the last reply byte
  localparam logic [3:0] WRITE_LEN  = 4'd8;
  localparam logic [3:0] READ_LEN   = 4'd4;
  localparam logic [3:0] REPLY_LAST = 4'd7;

  // index of the CRC byte in an outgoing frame
  localparam logic [2:0] WR_LAST_IDX = 3'd7;
  localparam logic [2:0] RD_LAST_IDX = 3'd3;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // one queued job: either a frame to send or a finished transaction
  typedef struct packed {
    logic        is_frame;
    logic        is_write;
    logic [1:0]  node;
    logic [6:0]  reg_addr;
    logic [31:0] data;
    status_e     status;
  } job_t;

  // CRC8, poly 0x07, byte taken LSB first into an MSB-side register
  function automatic logic [7:0] crc_feed(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[7] ^ b[i]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/urde_queue.sv
// Two-entry job queue between the front and back parts.
// Depends on urde_pkg (job_t, Q_DEPTH).
module urde_queue import urde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o
);

  job_t            mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]   count_q, count_d;

  assign full_o  = (count_q == (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (Q_AW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule

### sv/urde_front.sv
// Front part: accepts requests and received bytes, tracks echo and reply,
// checks the reply and queues jobs. Depends on urde_pkg.
module urde_front import urde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  node_addr_i,
  input  logic [6:0]  reg_addr_i,
  input  logic [31:0] wdata_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        job_o
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_ECHO  = 3'b010,
    PH_REPLY = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        read_q, read_d;
  logic [6:0]  preg_q, preg_d;
  logic [7:0]  crc_q, crc_d;
  logic [31:0] word_q, word_d;
  status_e     err_q, err_d;

  logic        accept;
  logic        busy;
  logic [3:0]  cnt_inc;
  logic [3:0]  echo_len;
  status_e     fin_err;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign busy       = (phase_q == PH_ECHO) || (phase_q == PH_REPLY);
  assign cnt_inc    = cnt_q + 4'd1;
  assign echo_len   = read_q ? READ_LEN : WRITE_LEN;
  assign fin_err    = ((err_q == ST_OK) && (rx_byte_i != crc_q)) ? ST_CRC : err_q;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    read_d  = read_q;
    preg_d  = preg_q;
    crc_d   = crc_q;
    word_d  = word_q;
    err_d   = err_q;
    push_o  = 1'b0;

    job_o.is_frame = 1'b1;
    job_o.is_write = (cmd_i == CMD_WRITE);
    job_o.node     = node_addr_i;
    job_o.reg_addr = reg_addr_i;
    job_o.data     = wdata_i;
    job_o.status   = ST_OK;

    if (accept) begin
      case (cmd_i)
        CMD_WRITE, CMD_READ: begin
          if (!busy) begin
            push_o  = 1'b1;
            phase_d = PH_ECHO;
            cnt_d   = '0;
            read_d  = (cmd_i == CMD_READ);
            preg_d  = reg_addr_i;
            crc_d   = '0;
            word_d  = '0;
            err_d   = ST_OK;
          end
        end
        CMD_RX: begin
          case (phase_q)
            PH_ECHO: begin
              if (cnt_inc < echo_len) begin
                cnt_d = cnt_inc;
              end else begin
                cnt_d = '0;
                if (!read_q) begin
                  // write finished after its echo
                  push_o         = 1'b1;
                  job_o.is_frame = 1'b0;
                  job_o.data     = '0;
                  phase_d        = PH_IDLE;
                end else begin
                  phase_d = PH_REPLY;
                  crc_d   = '0;
                  word_d  = '0;
                  err_d   = ST_OK;
                end
              end
            end
            PH_REPLY: begin
              if (cnt_q < REPLY_LAST) begin
                if (err_q == ST_OK) begin
                  if (cnt_q == 4'd0 && rx_byte_i != SYNC_BYTE) begin
                    err_d = ST_SYNC;
                  end else if (cnt_q == 4'd1 && rx_byte_i != MASTER_BYTE) begin
                    err_d = ST_MASTER;
                  end else if (cnt_q == 4'd2 && rx_byte_i != {1'b0, preg_q}) begin
                    err_d = ST_REG;
                  end
                end
                if (cnt_q >= 4'd3) begin
                  word_d = {word_q[23:0], rx_byte_i};
                end
                crc_d = crc_feed(crc_q, rx_byte_i);
                cnt_d = cnt_inc;
              end else begin
                push_o         = 1'b1;
                job_o.is_frame = 1'b0;
                job_o.status   = fin_err;
                job_o.data     = (fin_err == ST_OK) ? word_q : '0;
                err_d          = fin_err;
                phase_d        = PH_IDLE;
                cnt_d          = '0;
                read_d         = 1'b0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      read_q  <= 1'b0;
      preg_q  <= '0;
      crc_q   <= '0;
      word_q  <= '0;
      err_q   <= ST_OK;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      read_q  <= read_d;
      preg_q  <= preg_d;
      crc_q   <= crc_d;
      word_q  <= word_d;
      err_q   <= err_d;
    end
  end

  a_reply_is_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_REPLY) |-> read_q)
    else $error("reply phase without a pending read");

  a_push_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept && ((!busy && job_o.is_frame) || (busy && !job_o.is_frame)))
    else $error("job queued outside a valid request or finish");

endmodule

### sv/urde_back.sv
// Back part: serializes queued frames into bytes with a running CRC8 and
// emits finish results through the output register. Depends on urde_pkg.
module urde_back import urde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  job_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [2:0]  status_o,
  output logic [31:0] rdata_o
);

  logic        busy_q, busy_d;
  job_t        job_q, job_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  crc_q, crc_d;
  logic        ov_q, ov_d;
  logic        kind_q, kind_d;
  logic [7:0]  tx_q, tx_d;
  logic        last_q, last_d;
  status_e     st_q, st_d;
  logic [31:0] rd_q, rd_d;

  logic        adv;
  logic [2:0]  last_idx;
  logic        at_last;
  logic [7:0]  cur_byte;

  function automatic logic [7:0] frame_byte(job_t j, logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = SYNC_BYTE;
      3'd1:    b = {6'd0, j.node};
      3'd2:    b = {j.is_write, j.reg_addr};
      3'd3:    b = j.data[31:24];
      3'd4:    b = j.data[23:16];
      3'd5:    b = j.data[15:8];
      3'd6:    b = j.data[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

  assign adv      = !ov_q || out_ready_i;
  assign last_idx = job_q.is_write ? WR_LAST_IDX : RD_LAST_IDX;
  assign at_last  = (idx_q == last_idx);
  assign cur_byte = at_last ? crc_q : frame_byte(job_q, idx_q);

  always_comb begin
    busy_d = busy_q;
    job_d  = job_q;
    idx_d  = idx_q;
    crc_d  = crc_q;
    ov_d   = ov_q;
    kind_d = kind_q;
    tx_d   = tx_q;
    last_d = last_q;
    st_d   = st_q;
    rd_d   = rd_q;
    pop_o  = 1'b0;

    if (adv) begin
      ov_d = 1'b0;
      if (busy_q) begin
        ov_d   = 1'b1;
        kind_d = KIND_TX;
        tx_d   = cur_byte;
        last_d = at_last;
        st_d   = ST_OK;
        rd_d   = '0;
        crc_d  = crc_feed(crc_q, cur_byte);
        idx_d  = idx_q + 3'd1;
        if (at_last) begin
          busy_d = 1'b0;
        end
      end else if (!q_empty_i) begin
        pop_o = 1'b1;
        ov_d  = 1'b1;
        if (head_i.is_frame) begin
          // sync byte goes out as the job is taken
          job_d  = head_i;
          busy_d = 1'b1;
          kind_d = KIND_TX;
          tx_d   = SYNC_BYTE;
          last_d = 1'b0;
          st_d   = ST_OK;
          rd_d   = '0;
          crc_d  = crc_feed(8'h00, SYNC_BYTE);
          idx_d  = 3'd1;
        end else begin
          kind_d = KIND_DONE;
          tx_d   = '0;
          last_d = 1'b0;
          st_d   = head_i.status;
          rd_d   = head_i.data;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    crc_q  <= crc_d;
    kind_q <= kind_d;
    tx_q   <= tx_d;
    last_q <= last_d;
    st_q   <= st_d;
    rd_q   <= rd_d;
  end

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign tx_byte_o   = tx_q;
  assign last_o      = last_q;
  assign status_o    = st_q;
  assign rdata_o     = rd_q;

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && kind_q == KIND_DONE) |-> (tx_q == 8'h00 && !last_q))
    else $error("finish result carries transmit fields");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !busy_q)
    else $error("job taken while a frame is still being sent");

endmodule

### sv/uart_register_datagram_engine_top.sv
// Top level of the UART register datagram engine (host side).
// An accepted request is stored in the job queue, then the back part loads its first byte into the
// output register; the frame streams one byte per cycle (8 for a write, 4 for a read) while
// out_ready_i holds. Throughput: one input item per cycle while the job queue has room; the byte
// serializer sets the output pace at one result per cycle while out_ready_i is high. Reset (rst_ni
// low, async) returns to idle, empty queue. Depends on urde_pkg, urde_front, urde_queue and urde_back.
module uart_register_datagram_engine_top import urde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  node_addr_i,
  input  logic [6:0]  reg_addr_i,
  input  logic [31:0] wdata_i,
  input  logic [7:0]  rx_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [2:0]  status_o,
  output logic [31:0] rdata_o
);

  // Front part decides everything at accept time (busy checks, echo count,
  // reply checks) and queues a frame job for each request and a finish job at its end.
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  urde_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .node_addr_i (node_addr_i),
    .reg_addr_i  (reg_addr_i),
    .wdata_i     (wdata_i),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Short queue so the front keeps taking items while frames drain.
  urde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_job)
  );

  // Back part turns each job into transmit bytes (CRC built on the fly)
  // or a single finish result, behind a registered output stage.
  urde_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .tx_byte_o   (tx_byte_o),
    .last_o      (last_o),
    .status_o    (status_o),
    .rdata_o     (rdata_o)
  );

endmodule

### tb/tb_uart_register_datagram_engine_top.sv
// Self-checking testbench for uart_register_datagram_engine_top: directed table, then random
// write/read transactions with echoes and replies, checked against a cycle-free predictor.
// Depends on urde_pkg and the engine RTL only.
module tb_uart_register_datagram_engine_top;
  timeunit 1ns;
  timeprecision 1ps;
  import urde_pkg::*;

  // unused command code, must be ignored by the block
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 20;

  // link state as seen by the predictor
  typedef enum logic [1:0] {
    LINK_IDLE  = 2'd0,
    LINK_ECHO  = 2'd1,
    LINK_REPLY = 2'd2
  } link_phase_e;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL, // predictor supplies the results
    CHK_NONE,  // no result expected
    CHK_DONE   // one completion with a typed-in status, rdata 0
  } check_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  node;
    logic [6:0]  reg_addr;
    logic [31:0] wdata;
    logic [7:0]  rx;
  } host_req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        last;
    logic [2:0]  status;
    logic [31:0] rdata;
  } dgram_result_t;

  typedef struct packed {
    host_req_t req;
    check_e    chk;
    status_e   st;
  } table_row_t;

  // DUT signals
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [1:0]  node_addr_i;
  logic [6:0]  reg_addr_i;
  logic [31:0] wdata_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [2:0]  status_o;
  logic [31:0] rdata_o;

  // predictor state
  link_phase_e link_phase;
  logic [3:0]  byte_cnt;
  logic [3:0]  echo_len;
  logic        read_pend;
  logic [6:0]  pend_reg;
  logic [7:0]  crc_acc;
  logic [31:0] word_acc;
  status_e     first_err;

  dgram_result_t expected_results[$];
  table_row_t    directed_rows[$];

  int errors      = 0;
  int cycles      = 0;
  int items_taken = 0;
  bit no_idle     = 1'b0;  // both sides stop idling while set
  bit hold_req    = 1'b0;  // asks the receiver for one long hold-off

  uart_register_datagram_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .node_addr_i (node_addr_i),
    .reg_addr_i  (reg_addr_i),
    .wdata_i     (wdata_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .tx_byte_o   (tx_byte_o),
    .last_o      (last_o),
    .status_o    (status_o),
    .rdata_o     (rdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Global watchdog: a hung handshake or a lost completion ends up here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // CRC8, poly 0x07, zero start, data bits taken LSB first.
  function automatic logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] data);
    logic [7:0] a;
    a = acc;
    for (int k = 0; k < 8; k++) begin
      if (a[7] ^ data[k]) begin
        a = {a[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        a = {a[6:0], 1'b0};
      end
    end
    return a;
  endfunction

  function automatic dgram_result_t make_result(logic kind, logic [7:0] tx, logic last,
                                                logic [2:0] status, logic [31:0] rdata);
    dgram_result_t r;
    r.kind   = kind;
    r.tx     = tx;
    r.last   = last;
    r.status = status;
    r.rdata  = rdata;
    return r;
  endfunction

  function automatic host_req_t make_req(logic [1:0] cmd, logic [1:0] node, logic [6:0] reg_addr,
                                         logic [31:0] wdata, logic [7:0] rx);
    host_req_t q;
    q.cmd      = cmd;
    q.node     = node;
    q.reg_addr = reg_addr;
    q.wdata    = wdata;
    q.rx       = rx;
    return q;
  endfunction

  task automatic link_reset();
    link_phase = LINK_IDLE;
    byte_cnt   = '0;
    echo_len   = '0;
    read_pend  = 1'b0;
    pend_reg   = '0;
    crc_acc    = '0;
    word_acc   = '0;
    first_err  = ST_OK;
  endtask

  // Advances the link state by one accepted item. Results go to the expectation
  // queue only when keep is set; took tells whether the item did anything.
  task automatic predict_datagram(host_req_t it, bit keep, output bit took);
    logic [7:0] frame [0:7];
    logic [7:0] c;
    int         n;
    bit         busy;
    took = 1'b0;
    busy = (link_phase != LINK_IDLE);
    if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
      if (busy) return;  // request while busy is dropped
      took = 1'b1;
      frame[0] = SYNC_BYTE;
      frame[1] = {6'b0, it.node};
      if (it.cmd == CMD_WRITE) begin
        frame[2] = {1'b1, it.reg_addr};
        frame[3] = it.wdata[31:24];
        frame[4] = it.wdata[23:16];
        frame[5] = it.wdata[15:8];
        frame[6] = it.wdata[7:0];
        n = 8;
      end else begin
        frame[2] = {1'b0, it.reg_addr};
        n = 4;
      end
      c = 8'h00;
      for (int i = 0; i < n - 1; i++) c = crc8_step(c, frame[i]);
      frame[n-1] = c;
      link_phase = LINK_ECHO;
      byte_cnt   = '0;
      echo_len   = (it.cmd == CMD_WRITE) ? WRITE_LEN : READ_LEN;
      read_pend  = (it.cmd == CMD_READ);
      pend_reg   = it.reg_addr;
      crc_acc    = '0;
      word_acc   = '0;
      first_err  = ST_OK;
      if (keep) begin
        for (int i = 0; i < n; i++) begin
          expected_results.push_back(make_result(KIND_TX, frame[i], i == n - 1, ST_OK, 32'h0));
        end
      end
      return;
    end
    if (it.cmd != CMD_RX || !busy) return;  // unused code, or stray byte while idle
    took = 1'b1;
    if (link_phase == LINK_ECHO) begin
      // echo bytes are only counted
      byte_cnt = byte_cnt + 4'd1;
      if (byte_cnt < echo_len) return;
      byte_cnt = '0;
      if (!read_pend) begin
        link_phase = LINK_IDLE;
        if (keep) expected_results.push_back(make_result(KIND_DONE, 8'h00, 1'b0, ST_OK, 32'h0));
        return;
      end
      link_phase = LINK_REPLY;
      crc_acc    = '0;
      word_acc   = '0;
      first_err  = ST_OK;
      return;
    end
    if (byte_cnt < REPLY_LAST) begin
      // only the first failing header check sticks
      if (first_err == ST_OK) begin
        if (byte_cnt == 4'd0 && it.rx != SYNC_BYTE) first_err = ST_SYNC;
        else if (byte_cnt == 4'd1 && it.rx != MASTER_BYTE) first_err = ST_MASTER;
        else if (byte_cnt == 4'd2 && it.rx != {1'b0, pend_reg}) first_err = ST_REG;
      end
      if (byte_cnt >= 4'd3) word_acc = {word_acc[23:0], it.rx};
      crc_acc  = crc8_step(crc_acc, it.rx);
      byte_cnt = byte_cnt + 4'd1;
      return;
    end
    if (first_err == ST_OK && it.rx != crc_acc) first_err = ST_CRC;
    if (keep) begin
      expected_results.push_back(make_result(KIND_DONE, 8'h00, 1'b0, first_err,
                                             first_err == ST_OK ? word_acc : 32'h0));
    end
    link_phase = LINK_IDLE;
    byte_cnt   = '0;
    read_pend  = 1'b0;
  endtask

  // Offers one input transaction, starting and ending at a falling edge. The
  // predictor runs at the accepting rising edge so expectations lead the DUT.
  task automatic offer(host_req_t it, check_e chk, status_e st);
    bit took;
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < 11) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i       = it.cmd;
    node_addr_i = it.node;
    reg_addr_i  = it.reg_addr;
    wdata_i     = it.wdata;
    rx_byte_i   = it.rx;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_datagram(it, chk == CHK_MODEL, took);
    if (chk == CHK_DONE) expected_results.push_back(make_result(KIND_DONE, 8'h00, 1'b0, st, 32'h0));
    if (took) items_taken++;
    @(negedge clk_i);
  endtask

  task automatic offer_rx(logic [7:0] b);
    offer(make_req(CMD_RX, 2'($urandom), 7'($urandom), $urandom, b), CHK_MODEL, ST_OK);
  endtask

  task automatic add_row(logic [1:0] cmd, logic [1:0] node, logic [6:0] reg_addr,
                         logic [31:0] wdata, logic [7:0] rx, check_e chk, status_e st);
    table_row_t row;
    row.req = make_req(cmd, node, reg_addr, wdata, rx);
    row.chk = chk;
    row.st  = st;
    directed_rows.push_back(row);
  endtask

  // A request issued while the link is busy must be dropped.
  task automatic maybe_busy_request();
    if ($urandom_range(0, 3) == 0) begin
      offer(make_req(2'($urandom_range(0, 1)), 2'($urandom), 7'($urandom), $urandom, 8'($urandom)),
            CHK_MODEL, ST_OK);
    end
  endtask

  task automatic run_write();
    offer(make_req(CMD_WRITE, 2'($urandom), 7'($urandom), $urandom, 8'($urandom)), CHK_MODEL, ST_OK);
    maybe_busy_request();
    for (int i = 0; i < WRITE_LEN; i++) offer_rx(8'($urandom));
  endtask

  // Read with a well-formed reply, sometimes spoiled in one or two places.
  task automatic run_read();
    logic [7:0] reply [0:7];
    logic [6:0] reg_addr;
    logic [7:0] c;
    int         flaw;
    reg_addr = 7'($urandom);
    offer(make_req(CMD_READ, 2'($urandom), reg_addr, $urandom, 8'($urandom)), CHK_MODEL, ST_OK);
    maybe_busy_request();
    for (int i = 0; i < READ_LEN; i++) offer_rx(8'($urandom));
    reply[0] = SYNC_BYTE;
    reply[1] = MASTER_BYTE;
    reply[2] = {1'b0, reg_addr};
    for (int i = 3; i < 7; i++) reply[i] = 8'($urandom);
    flaw = $urandom_range(0, 11);
    case (flaw)
      0: reply[0] = reply[0] ^ 8'($urandom_range(1, 255));
      1: reply[1] = reply[1] ^ 8'($urandom_range(1, 255));
      2: reply[2] = reply[2] ^ 8'($urandom_range(1, 255));
      3: begin
        // sync and register both wrong: sync must win
        reply[0] = reply[0] ^ 8'($urandom_range(1, 255));
        reply[2] = reply[2] ^ 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    c = 8'h00;
    for (int i = 0; i < 7; i++) c = crc8_step(c, reply[i]);
    reply[7] = c;
    if (flaw == 4) reply[7] = reply[7] ^ 8'($urandom_range(1, 255));
    if (flaw == 5) reply[$urandom_range(3, 6)] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < 8; i++) offer_rx(reply[i]);
  endtask

  // Receiver: random back-pressure, a quiet stretch, and one long hold-off
  // during which the sender keeps pushing until the input side stalls.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i = no_idle || ($urandom_range(0, 99) >= 11);
    end
  end

  // Result checker: every accepted result must match the oldest expectation.
  always @(posedge clk_i) begin : result_check
    dgram_result_t got;
    dgram_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = make_result(kind_o, tx_byte_o, last_o, status_o, rdata_o);
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d tx=%02h last=%0d status=%0d rdata=%08h",
                 $time, got.kind, got.tx, got.last, got.status, got.rdata);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected kind=%0d tx=%02h last=%0d status=%0d rdata=%08h",
                   $time, want.kind, want.tx, want.last, want.status, want.rdata);
          $display("%0t:          actual   kind=%0d tx=%02h last=%0d status=%0d rdata=%08h",
                   $time, got.kind, got.tx, got.last, got.status, got.rdata);
        end
      end
    end
  end

  // Main stimulus: reset, directed table, random transactions, drain, verdict.
  initial begin : stimulus
    bit hold_done;
    int pick;
    hold_done   = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_WRITE;
    node_addr_i = '0;
    reg_addr_i  = '0;
    wdata_i     = '0;
    rx_byte_i   = '0;
    link_reset();

    // stray byte and unused command while idle: both dropped
    add_row(CMD_RX,     2'd0, 7'h00, 32'h0,        8'hFF, CHK_NONE,  ST_OK);
    add_row(CMD_UNUSED, 2'd3, 7'h7F, 32'hFFFFFFFF, 8'hFF, CHK_NONE,  ST_OK);
    // write with all-ones fields; requests during its echo are dropped
    add_row(CMD_WRITE,  2'd3, 7'h7F, 32'hFFFFFFFF, 8'h00, CHK_MODEL, ST_OK);
    add_row(CMD_READ,   2'd0, 7'h00, 32'h0,        8'h00, CHK_NONE,  ST_OK);
    add_row(CMD_WRITE,  2'd0, 7'h00, 32'h0,        8'h00, CHK_NONE,  ST_OK);
    // echo content is not checked, only counted
    for (int i = 0; i < 7; i++) begin
      add_row(CMD_RX, 2'd0, 7'h00, 32'h0, (i % 2) ? 8'hFF : 8'h00, CHK_NONE, ST_OK);
    end
    add_row(CMD_RX,     2'd0, 7'h00, 32'h0,        8'hA5, CHK_DONE,  ST_OK);
    // read with all-zero fields, reply with bad sync, bad master and bad register: sync wins
    add_row(CMD_READ,   2'd0, 7'h00, 32'h0,        8'h00, CHK_MODEL, ST_OK);
    for (int i = 0; i < 4; i++) add_row(CMD_RX, 2'd0, 7'h00, 32'h0, 8'h5A, CHK_NONE, ST_OK);
    add_row(CMD_RX,     2'd0, 7'h00, 32'h0,        8'h00, CHK_NONE,  ST_OK);
    add_row(CMD_RX,     2'd0, 7'h00, 32'h0,        8'h00, CHK_NONE,  ST_OK);
    add_row(CMD_RX,     2'd0, 7'h00, 32'h0,        8'h7F, CHK_NONE,  ST_OK);
    for (int i = 0; i < 4; i++) add_row(CMD_RX, 2'd0, 7'h00, 32'h0, 8'hFF, CHK_NONE, ST_OK);
    add_row(CMD_RX,     2'd0, 7'h00, 32'h0,        8'h00, CHK_DONE,  ST_SYNC);

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) offer(directed_rows[i].req, directed_rows[i].chk, directed_rows[i].st);

    // random part: mostly complete transactions, some noise
    items_taken = 0;
    while (items_taken < RANDOM_ITEMS) begin
      if (items_taken >= 40 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      no_idle = (items_taken >= 90 && items_taken < 130);
      pick    = $urandom_range(0, 99);
      if (link_phase != LINK_IDLE) begin
        // noise left a transaction open: finish it with random bytes
        offer_rx(8'($urandom));
      end else if (pick < 40) begin
        run_read();
      end else if (pick < 75) begin
        run_write();
      end else begin
        offer(make_req(2'($urandom_range(0, 3)), 2'($urandom), 7'($urandom), $urandom,
                       8'($urandom)), CHK_MODEL, ST_OK);
      end
    end
    no_idle    = 1'b0;
    in_valid_i = 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
